### hw/rtl/sha_pkg.sv
// Shared types, constants and a rotate helper for the SHA-256 stream hasher.
// No dependencies.
`timescale 1ns / 1ps

package sha_pkg;

    // Initial hash values.
    localparam logic [31:0] INIT_H [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    // Round constants.
    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
        32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
        32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
        32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
        32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
        32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [7:0] PAD_BYTE = 8'h80;

    // Controller states, one-hot.
    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_COMP  = 6'b000010,
        ST_PAD1  = 6'b000100,
        ST_PAD2  = 6'b001000,
        ST_FOLD  = 6'b010000,
        ST_OUT   = 6'b100000
    } state_t;

    // Commands from controller to datapath.
    typedef struct packed {
        logic       take_byte;   // write s byte, bump count
        logic       start_pad1;  // load first pad block into the buffer
        logic       start_pad2;  // load length-only block
        logic       round;       // run one compression round
        logic       load_vars;   // copy chaining value into working vars
        logic       fold;        // add working vars into chaining value
        logic       reset_msg;   // restore initial hash values and count
    } dp_cmd_t;

    // Status from datapath to controller.
    typedef struct packed {
        logic       block_full;  // byte position is 63
        logic       two_pad;     // padding needs two blocks
        logic       last_round;  // round counter at 63
    } dp_stat_t;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

endpackage

### hw/rtl/sha_datapath.sv
// Datapath: block buffer, message schedule, round logic and chaining value.
// Depends on sha_pkg.
`timescale 1ns / 1ps

module sha_datapath (
    input  logic              aclk,
    input  logic              aresetn,
    input  sha_pkg::dp_cmd_t  cmd,
    input  logic [7:0]        byte_in,
    input  logic [2:0]        out_sel,
    output sha_pkg::dp_stat_t stat,
    output logic [31:0]       digest_word
);

    // Block held as sixteen 32-bit words; also serves as schedule window.
    logic [31:0] w_reg [16];
    logic [31:0] w_next [16];
    logic [31:0] h_reg [8];
    logic [31:0] v_reg [8];
    logic [60:0] cnt_reg;
    logic [5:0]  rnd_reg;
    logic [5:0]  pos;
    logic [63:0] bits;
    logic [31:0] s0, s1, wnew, t1, t2, big0, big1, ch, maj;

    assign pos  = cnt_reg[5:0];
    assign bits = {cnt_reg, 3'b000};

    assign stat.block_full = (pos == 6'd63);
    assign stat.two_pad    = (pos >= 6'd56);
    assign stat.last_round = (rnd_reg == 6'd63);

    // Schedule word for the next window slot.
    assign s0   = sha_pkg::rotr(w_reg[1], 7) ^ sha_pkg::rotr(w_reg[1], 18) ^ (w_reg[1] >> 3);
    assign s1   = sha_pkg::rotr(w_reg[14], 17) ^ sha_pkg::rotr(w_reg[14], 19)
                ^ (w_reg[14] >> 10);
    assign wnew = s1 + w_reg[9] + s0 + w_reg[0];

    // Round function.
    assign big1 = sha_pkg::rotr(v_reg[4], 6) ^ sha_pkg::rotr(v_reg[4], 11)
                ^ sha_pkg::rotr(v_reg[4], 25);
    assign ch   = (v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]);
    assign t1   = v_reg[7] + big1 + ch + sha_pkg::ROUND_K[rnd_reg] + w_reg[0];
    assign big0 = sha_pkg::rotr(v_reg[0], 2) ^ sha_pkg::rotr(v_reg[0], 13)
                ^ sha_pkg::rotr(v_reg[0], 22);
    assign maj  = (v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]);
    assign t2   = big0 + maj;

    assign digest_word = h_reg[out_sel];

    // Next window contents.
    always_comb begin
        for (int i = 0; i < 16; i++) begin
            w_next[i] = w_reg[i];
        end
        if (cmd.take_byte) begin
            w_next[pos[5:2]] = w_reg[pos[5:2]];
            unique case (pos[1:0])
                2'd0: w_next[pos[5:2]][31:24] = byte_in;
                2'd1: w_next[pos[5:2]][23:16] = byte_in;
                2'd2: w_next[pos[5:2]][15:8]  = byte_in;
                default: w_next[pos[5:2]][7:0] = byte_in;
            endcase
        end else if (cmd.start_pad1) begin
            // Keep bytes below pos, place 0x80, zero the rest; add the bit length if pos < 56.
            for (int i = 0; i < 16; i++) begin
                for (int b = 0; b < 4; b++) begin
                    if (6'(i * 4 + b) == pos) begin
                        w_next[i][31 - 8 * b -: 8] = sha_pkg::PAD_BYTE;
                    end else if (6'(i * 4 + b) > pos) begin
                        w_next[i][31 - 8 * b -: 8] = 8'h00;
                    end
                end
            end
            if (pos < 6'd56) begin
                w_next[14] = bits[63:32];
                w_next[15] = bits[31:0];
            end
        end else if (cmd.start_pad2) begin
            for (int i = 0; i < 14; i++) begin
                w_next[i] = '0;
            end
            w_next[14] = bits[63:32];
            w_next[15] = bits[31:0];
        end else if (cmd.round) begin
            for (int i = 0; i < 15; i++) begin
                w_next[i] = w_reg[i + 1];
            end
            w_next[15] = wnew;
        end
    end

    // Window registers.
    always_ff @(posedge aclk) begin
        for (int i = 0; i < 16; i++) begin
            w_reg[i] <= w_next[i];
        end
    end

    // Working variables.
    always_ff @(posedge aclk) begin
        if (cmd.load_vars) begin
            for (int i = 0; i < 8; i++) begin
                v_reg[i] <= h_reg[i];
            end
        end else if (cmd.round) begin
            v_reg[0] <= t1 + t2;
            v_reg[1] <= v_reg[0];
            v_reg[2] <= v_reg[1];
            v_reg[3] <= v_reg[2];
            v_reg[4] <= v_reg[3] + t1;
            v_reg[5] <= v_reg[4];
            v_reg[6] <= v_reg[5];
            v_reg[7] <= v_reg[6];
        end
    end

    // Chaining value, byte count and round counter.
    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.reset_msg) begin
            for (int i = 0; i < 8; i++) begin
                h_reg[i] <= sha_pkg::INIT_H[i];
            end
            cnt_reg <= '0;
            rnd_reg <= '0;
        end else begin
            if (cmd.fold) begin
                for (int i = 0; i < 8; i++) begin
                    h_reg[i] <= h_reg[i] + v_reg[i];
                end
            end
            if (cmd.take_byte) begin
                cnt_reg <= cnt_reg + 61'd1;
            end
            if (cmd.round) begin
                rnd_reg <= rnd_reg + 6'd1;
            end
        end
    end

endmodule

### hw/rtl/sha_ctrl.sv
// Controller: sequences byte intake, compressions, padding and digest output.
// Depends on sha_pkg.
`timescale 1ns / 1ps

module sha_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic              has_byte,
    input  logic              last_in,
    output logic              m_tvalid,
    input  logic              m_tready,
    input  sha_pkg::dp_stat_t stat,
    output sha_pkg::dp_cmd_t  cmd,
    output logic [2:0]        out_sel
);

    sha_pkg::state_t state_reg, state_next;
    logic            last_reg, last_next;
    logic            pad2_reg, pad2_next;
    logic [2:0]      idx_reg, idx_next;
    logic            pad_done_reg, pad_done_next;
    logic            acc;

    assign s_tready = (state_reg == sha_pkg::ST_IDLE);
    assign m_tvalid = (state_reg == sha_pkg::ST_OUT);
    assign acc      = s_tvalid && s_tready;
    assign out_sel  = idx_reg;

    // Next state and commands.
    always_comb begin
        state_next = state_reg;
        last_next  = last_reg;
        pad2_next  = pad2_reg;
        idx_next   = idx_reg;
        cmd        = '0;
        unique case (state_reg)
            sha_pkg::ST_IDLE: begin
                if (acc) begin
                    last_next = last_in;
                    pad2_next = 1'b0;
                    if (has_byte) begin
                        cmd.take_byte = 1'b1;
                        if (stat.block_full) begin
                            state_next = sha_pkg::ST_COMP;
                        end else if (last_in) begin
                            state_next = sha_pkg::ST_PAD1;
                        end
                    end else if (last_in) begin
                        state_next = sha_pkg::ST_PAD1;
                    end
                end
            end
            sha_pkg::ST_PAD1: begin
                cmd.start_pad1 = 1'b1;
                pad2_next      = stat.two_pad;
                state_next     = sha_pkg::ST_COMP;
            end
            sha_pkg::ST_PAD2: begin
                cmd.start_pad2 = 1'b1;
                pad2_next      = 1'b0;
                state_next     = sha_pkg::ST_COMP;
            end
            sha_pkg::ST_COMP: begin
                // One round per cycle; the working variables were loaded on entry.
                cmd.round = 1'b1;
                if (stat.last_round) begin
                    state_next = sha_pkg::ST_FOLD;
                end
            end
            sha_pkg::ST_FOLD: begin
                cmd.fold = 1'b1;
                if (pad2_reg) begin
                    state_next = sha_pkg::ST_PAD2;
                end else if (last_reg) begin
                    // A block ended by the last byte still needs padding.
                    state_next = sha_pkg::ST_PAD1;
                    last_next  = 1'b0;
                end else if (pad_done_reg) begin
                    state_next = sha_pkg::ST_OUT;
                    idx_next   = 3'd0;
                end else begin
                    state_next = sha_pkg::ST_IDLE;
                end
            end
            sha_pkg::ST_OUT: begin
                if (m_tready) begin
                    idx_next = idx_reg + 3'd1;
                    if (idx_reg == 3'd7) begin
                        cmd.reset_msg = 1'b1;
                        state_next    = sha_pkg::ST_IDLE;
                    end
                end
            end
            default: state_next = sha_pkg::ST_IDLE;
        endcase
        // Working variables follow the chaining value before every block.
        cmd.load_vars = (state_next == sha_pkg::ST_COMP) && (state_reg != sha_pkg::ST_COMP);
    end

    // Marks that the current compressions are padding blocks.
    always_comb begin
        pad_done_next = pad_done_reg;
        if (state_reg == sha_pkg::ST_PAD1) begin
            pad_done_next = 1'b1;
        end else if (state_reg == sha_pkg::ST_OUT) begin
            pad_done_next = 1'b0;
        end
    end

    // State registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= sha_pkg::ST_IDLE;
            last_reg     <= 1'b0;
            pad2_reg     <= 1'b0;
            idx_reg      <= 3'd0;
            pad_done_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            last_reg     <= (state_reg == sha_pkg::ST_PAD1) ? 1'b0 : last_next;
            pad2_reg     <= pad2_next;
            idx_reg      <= idx_next;
            pad_done_reg <= pad_done_next;
        end
    end

    // Input is never taken while a digest is pending.
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready) else $error("input ready during output");
    // Digest words leave in order.
    a_idx_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && idx_reg != 3'd7) |=> (idx_reg == $past(idx_reg) + 3'd1))
        else $error("word index skipped");
    // A compression always ends in a fold.
    a_fold: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == sha_pkg::ST_COMP && stat.last_round) |=> (state_reg == sha_pkg::ST_FOLD))
        else $error("missing fold");

endmodule

### hw/rtl/sha256_stream_hasher.sv
// SHA-256 stream hasher, top level: joins the controller and the datapath.
// Depends on sha_pkg, sha_ctrl and sha_datapath.
`timescale 1ns / 1ps
//
// Usage: message bytes enter one per transfer on the s_ channel. tdata holds
// the byte (has_byte in tuser[0] says it is valid) and tlast ends the
// message; an end transfer without a byte is allowed, so an empty message
// hashes too. The m_ channel then returns eight digest words, most
// significant first, with the word index in tuser and tlast on the eighth.
// Flow: a byte that neither fills a block nor ends the message leaves the
// input ready for the next byte. The 64th byte of a block starts a
// compression, run by the single round unit and followed by a fold, during
// which no byte is taken. The end of a message adds one or two padded
// compressions before the first digest word appears. Reset restores the
// initial hash values and clears the byte count. When the receiver stalls,
// the current word holds and no input is taken until all eight words are delivered.
module sha256_stream_hasher (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tuser,   // [0] has_byte
    input  logic        s_tlast,   // last_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] digest_word
    output logic [2:0]  m_tuser,   // [2:0] word_index
    output logic        m_tlast    // last_word
);

    sha_pkg::dp_cmd_t  cmd;
    sha_pkg::dp_stat_t stat;
    logic [2:0]        sel;

    sha_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .has_byte (s_tuser),
        .last_in  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd),
        .out_sel  (sel)
    );

    sha_datapath u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .byte_in     (s_tdata),
        .out_sel     (sel),
        .stat        (stat),
        .digest_word (m_tdata)
    );

    assign m_tuser = sel;
    assign m_tlast = (sel == 3'd7);

endmodule
